/* hw/rtl/ptc_pkg.sv */
// ptc_pkg: shared types, mode codes and constants of the pwm timer counter
`default_nettype none

package ptc_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_WAVEFORM  = 3'd0;
    localparam logic [2:0] CFG_PRESCALE  = 3'd1;
    localparam logic [2:0] CFG_COMPARE_A = 3'd2;
    localparam logic [2:0] CFG_COMPARE_B = 3'd3;
    localparam logic [2:0] CFG_COMPARE_C = 3'd4;

    // waveform modes
    localparam logic [3:0] WGM_FREE_RUN   = 4'd0;
    localparam logic [3:0] WGM_CTC_ICR    = 4'd1;
    localparam logic [3:0] WGM_CTC_OCRA   = 4'd2;
    localparam logic [3:0] WGM_FAST_8     = 4'd3;
    localparam logic [3:0] WGM_FAST_9     = 4'd4;
    localparam logic [3:0] WGM_FAST_10    = 4'd5;
    localparam logic [3:0] WGM_FAST_ICR   = 4'd6;
    localparam logic [3:0] WGM_FAST_OCRA  = 4'd7;
    localparam logic [3:0] WGM_PHASE_8    = 4'd8;
    localparam logic [3:0] WGM_PHASE_9    = 4'd9;
    localparam logic [3:0] WGM_PHASE_10   = 4'd10;
    localparam logic [3:0] WGM_PHASE_ICR  = 4'd11;
    localparam logic [3:0] WGM_PHASE_OCRA = 4'd12;
    localparam logic [3:0] WGM_PFC_ICR    = 4'd13;
    localparam logic [3:0] WGM_PFC_OCRA   = 4'd14;
    localparam logic [3:0] WGM_HOLD       = 4'd15;

    // compare output modes
    localparam logic [2:0] CM_OFF    = 3'd0;
    localparam logic [2:0] CM_TOGGLE = 3'd1;
    localparam logic [2:0] CM_CLEAR  = 3'd2;
    localparam logic [2:0] CM_SET    = 3'd3;
    localparam logic [2:0] CM_NONINV = 3'd4;
    localparam logic [2:0] CM_INV    = 3'd5;
    localparam logic [2:0] CM_CLRUP  = 3'd6;
    localparam logic [2:0] CM_SETUP  = 3'd7;

    // counting families
    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_FAST  = 2'd1;
    localparam logic [1:0] KIND_PHASE = 2'd2;

    // fixed tops
    localparam logic [9:0] TOP_8  = 10'h0ff;
    localparam logic [9:0] TOP_9  = 10'h1ff;
    localparam logic [9:0] TOP_10 = 10'h3ff;

    localparam logic [3:0] PRESCALE_MAX = 4'd11;

    typedef struct packed {
        logic [3:0]      waveform_mode;
        logic [3:0]      prescale_select;
        logic [2:0][2:0] compare_mode;
    } ptc_cfg_t;

    // low prescale_select-1 bits set
    function automatic logic [9:0] prescale_mask(input logic [3:0] sel);
        logic [9:0] m;
        case (sel)
            4'd2:    m = 10'h001;
            4'd3:    m = 10'h003;
            4'd4:    m = 10'h007;
            4'd5:    m = 10'h00f;
            4'd6:    m = 10'h01f;
            4'd7:    m = 10'h03f;
            4'd8:    m = 10'h07f;
            4'd9:    m = 10'h0ff;
            4'd10:   m = 10'h1ff;
            4'd11:   m = 10'h3ff;
            default: m = 10'h000;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/ptc_chan.sv */
// ptc_chan: output compare pin action and match detect of one channel
`default_nettype none

module ptc_chan
    import ptc_pkg::*;
#(
    parameter int TW = 16
)
(
    input  wire logic [1:0]    kind,
    input  wire logic [2:0]    cmode,
    input  wire logic          present,
    input  wire logic [TW-1:0] ocr,
    input  wire logic [TW-1:0] cnt,
    input  wire logic [TW-1:0] top,
    input  wire logic          count_down,
    input  wire logic          pin,
    output logic               pin_next,
    output logic               hit
);

    logic special;
    logic lowish;
    logic highish;
    logic at_top;
    logic lvl;

    always_comb
    begin
        lowish  = (cmode == CM_NONINV) || (cmode == CM_CLRUP);
        highish = (cmode == CM_INV) || (cmode == CM_SETUP);
        at_top  = (cnt == top);
        special = 1'b0;
        lvl     = pin;

        // extreme compare values pin the output
        if ((kind == KIND_FAST) && (cmode != CM_OFF))
        begin
            if (ocr == '0)
            begin
                lvl     = (cnt == '0);
                special = 1'b1;
            end
            else if (ocr == top)
            begin
                lvl     = (cmode == CM_INV);
                special = 1'b1;
            end
        end
        else if (kind == KIND_PHASE)
        begin
            if (((ocr == '0) && lowish) || ((ocr == top) && highish))
            begin
                lvl     = 1'b0;
                special = 1'b1;
            end
            else if (((ocr == '0) && highish) || ((ocr == top) && lowish))
            begin
                lvl     = 1'b1;
                special = 1'b1;
            end
        end

        // bottom action
        if ((cnt == '0) && !special)
        begin
            if (cmode == CM_NONINV)
                lvl = 1'b1;
            else if (cmode == CM_INV)
                lvl = 1'b0;
        end

        hit = present && (cnt == ocr);

        if (hit && (cmode != CM_OFF) && !special &&
            (!at_top || (cmode == CM_TOGGLE) || (cmode == CM_CLEAR) || (cmode == CM_SET)))
        begin
            case (cmode)
                CM_TOGGLE: lvl = ~lvl;
                CM_CLEAR:  lvl = 1'b0;
                CM_NONINV: lvl = 1'b0;
                CM_CLRUP:  lvl = count_down;
                CM_SETUP:  lvl = ~count_down;
                default:   lvl = 1'b1;
            endcase
        end

        pin_next = lvl;
    end

endmodule

`default_nettype wire

/* hw/rtl/ptc_step.sv */
// ptc_step: next timer state and result flags for one registered item
`default_nettype none

module ptc_step
    import ptc_pkg::*;
#(
    parameter int COUNTER_BITS = 16,
    parameter int NUM_COMPARE  = 3
)
(
    input  wire ptc_cfg_t                   cfg,
    input  wire logic                       op_write,
    input  wire logic [COUNTER_BITS-1:0]    new_count,
    input  wire logic [COUNTER_BITS-1:0]    icr,
    input  wire logic [2:0][COUNTER_BITS-1:0] ocr_buf,
    input  wire logic [9:0]                 prescale_count,
    input  wire logic [COUNTER_BITS-1:0]    counter,
    input  wire logic                       count_down,
    input  wire logic [2:0][COUNTER_BITS-1:0] shadow,
    input  wire logic [2:0]                 pins,
    output logic [9:0]                      prescale_count_next,
    output logic [COUNTER_BITS-1:0]         counter_next,
    output logic                            count_down_next,
    output logic [2:0][COUNTER_BITS-1:0]    shadow_next,
    output logic [2:0]                      pins_next,
    output logic                            overflow_hit,
    output logic [2:0]                      match_hit
);

    // compare width covers the fixed 10-bit tops
    localparam int TW = (COUNTER_BITS > 10) ? COUNTER_BITS : 10;
    localparam logic [TW-1:0] CMAX = TW'({COUNTER_BITS{1'b1}});

    logic [9:0]  pc_inc;
    logic        running;
    logic        cnt_tick;
    logic [TW-1:0] cnt_w;
    logic [TW-1:0] top_w;
    logic [TW-1:0] ovf_w;
    logic [TW-1:0] sync_w;
    logic [TW-1:0] rev_w;
    logic [TW-1:0] sha_w;
    logic [TW-1:0] icr_w;
    logic [1:0]  kind;
    logic        rev_follows;
    logic        do_sync;
    logic [2:0][COUNTER_BITS-1:0] ocr_eff;
    logic [2:0]  pin_calc;
    logic [2:0]  hit_calc;
    logic [TW:0] nxt;
    logic        dn;

    assign cnt_w = TW'(counter);
    assign sha_w = TW'(shadow[0]);
    assign icr_w = TW'(icr);

    // mode decode: top, overflow point and sync point
    always_comb
    begin
        kind        = KIND_PLAIN;
        rev_follows = 1'b0;
        top_w       = CMAX;
        ovf_w       = CMAX;
        sync_w      = cnt_w;
        case (cfg.waveform_mode)
            WGM_FREE_RUN:   top_w = CMAX;
            WGM_CTC_ICR:    top_w = icr_w;
            WGM_CTC_OCRA:   top_w = sha_w;
            WGM_FAST_8,
            WGM_FAST_9,
            WGM_FAST_10,
            WGM_FAST_ICR,
            WGM_FAST_OCRA:
            begin
                kind   = KIND_FAST;
                sync_w = '0;
                case (cfg.waveform_mode)
                    WGM_FAST_8:   top_w = TW'(TOP_8);
                    WGM_FAST_9:   top_w = TW'(TOP_9);
                    WGM_FAST_10:  top_w = TW'(TOP_10);
                    WGM_FAST_ICR: top_w = icr_w;
                    default:      top_w = sha_w;
                endcase
                ovf_w = top_w;
            end
            WGM_PHASE_8:    begin kind = KIND_PHASE; top_w = TW'(TOP_8);  sync_w = top_w; end
            WGM_PHASE_9:    begin kind = KIND_PHASE; top_w = TW'(TOP_9);  sync_w = top_w; end
            WGM_PHASE_10:   begin kind = KIND_PHASE; top_w = TW'(TOP_10); sync_w = top_w; end
            WGM_PHASE_ICR:  begin kind = KIND_PHASE; top_w = icr_w;       sync_w = top_w; end
            WGM_PHASE_OCRA:
            begin
                kind        = KIND_PHASE;
                top_w       = sha_w;
                sync_w      = top_w;
                rev_follows = 1'b1;
            end
            WGM_PFC_ICR:    begin kind = KIND_PHASE; top_w = icr_w; sync_w = '0; end
            default:
            begin
                kind        = KIND_PHASE;
                top_w       = sha_w;
                sync_w      = '0;
                rev_follows = 1'b1;
            end
        endcase
        if (kind == KIND_PHASE)
            ovf_w = '0;
    end

    assign do_sync = (sync_w == cnt_w);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            ocr_eff[i] = (do_sync && (i < NUM_COMPARE)) ? ocr_buf[i] : shadow[i];
        rev_w = (rev_follows && do_sync) ? TW'(ocr_eff[0]) : top_w;
    end

    genvar gi;
    generate
        for (gi = 0; gi < 3; gi++)
        begin : g_chan
            ptc_chan #(.TW(TW)) u_chan (
                .kind       (kind),
                .cmode      ((gi < NUM_COMPARE) ? cfg.compare_mode[gi] : CM_OFF),
                .present    (gi < NUM_COMPARE),
                .ocr        (TW'(ocr_eff[gi])),
                .cnt        (cnt_w),
                .top        (top_w),
                .count_down (count_down),
                .pin        (pins[gi]),
                .pin_next   (pin_calc[gi]),
                .hit        (hit_calc[gi])
            );
        end
    endgenerate

    // counter advance and direction
    always_comb
    begin
        dn = count_down;
        if (count_down)
        begin
            if (cnt_w == '0)
            begin
                nxt = '0;
                dn  = 1'b0;
            end
            else
            begin
                nxt = {1'b0, cnt_w} - 1'b1;
                if (nxt > {1'b0, top_w})
                begin
                    nxt = '0;
                    dn  = 1'b0;
                end
                else if (nxt == '0)
                    dn = 1'b0;
            end
        end
        else
        begin
            nxt = {1'b0, cnt_w} + 1'b1;
            if (nxt > {1'b0, top_w})
                nxt = '0;
        end
        if ((kind == KIND_PHASE) && (nxt == {1'b0, rev_w}))
            dn = ~dn;
    end

    assign running  = (cfg.prescale_select != 4'd0) && (cfg.prescale_select <= PRESCALE_MAX);
    assign pc_inc   = prescale_count + 10'd1;
    assign cnt_tick = ((pc_inc & prescale_mask(cfg.prescale_select)) == 10'd0);

    always_comb
    begin
        prescale_count_next = prescale_count;
        counter_next        = counter;
        count_down_next     = count_down;
        shadow_next         = shadow;
        pins_next           = pins;
        overflow_hit        = 1'b0;
        match_hit           = 3'b000;
        if (op_write)
            counter_next = new_count;
        else if (running)
        begin
            prescale_count_next = pc_inc;
            if (cnt_tick && (cfg.waveform_mode != WGM_HOLD))
            begin
                shadow_next     = ocr_eff;
                pins_next       = pin_calc;
                match_hit       = hit_calc;
                overflow_hit    = (cnt_w == ovf_w);
                counter_next    = nxt[COUNTER_BITS-1:0];
                count_down_next = dn;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pwm_timer_counter_core.sv */
// pwm_timer_counter_core: top level of the prescaled pwm timer counter
//
// item channel (item_valid/item_ready): one transfer per system tick, carrying
//   operation (0 tick, 1 counter write), new_count, the three software compare
//   buffers and capture_top
// result channel (result_valid/result_ready): one transfer per item with the
//   counter after the item, the three pin levels and the hit pulses
// config port: cfg_we writes cfg_data into register cfg_index (0 waveform mode,
//   1 prescale select, 2..4 compare modes a..c); the user writes only while the
//   block is idle, which the block itself does not enforce
// order: an item taken sits in the input register; its result is loaded into the
//   result register, raising result_valid, when that register is free or drained
// throughput: one item per cycle while results are taken; the timer state update
//   is a single pass of compare and increment logic between the input and result
//   registers; stall: while the result register is full and not taken, the input
//   register holds its item and item_ready drops once both stages are occupied
// reset: counter, prescaler, direction, shadow compares and pins clear to zero,
//   configuration clears to normal mode with the prescaler stopped
`default_nettype none

module pwm_timer_counter_core
    import ptc_pkg::*;
#(
    parameter int COUNTER_BITS = 16,
    parameter int NUM_COMPARE  = 3
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [3:0]  cfg_data,
    // item channel
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic        operation,
    input  wire logic [15:0] new_count,
    input  wire logic [15:0] ocr_a_buffer,
    input  wire logic [15:0] ocr_b_buffer,
    input  wire logic [15:0] ocr_c_buffer,
    input  wire logic [15:0] capture_top,
    // result channel
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [15:0]      count_now,
    output logic             pin_a,
    output logic             pin_b,
    output logic             pin_c,
    output logic             overflow_hit,
    output logic             match_a_hit,
    output logic             match_b_hit,
    output logic             match_c_hit
);

    // configuration registers
    ptc_cfg_t cfg_reg;

    // input stage
    logic        in_valid_reg;
    logic        op_reg;
    logic [15:0] new_count_reg;
    logic [15:0] ocr_a_reg;
    logic [15:0] ocr_b_reg;
    logic [15:0] ocr_c_reg;
    logic [15:0] icr_reg;

    // timer state
    logic [9:0]                      pc_reg;
    logic [9:0]                      pc_next;
    logic [COUNTER_BITS-1:0]         counter_reg;
    logic [COUNTER_BITS-1:0]         counter_next;
    logic                            down_reg;
    logic                            down_next;
    logic [2:0][COUNTER_BITS-1:0]    shadow_reg;
    logic [2:0][COUNTER_BITS-1:0]    shadow_next;
    logic [2:0]                      pins_reg;
    logic [2:0]                      pins_next;
    logic                            ovf_calc;
    logic [2:0]                      hit_calc;

    // result stage
    logic        out_valid_reg;
    logic [15:0] count_now_reg;
    logic [2:0]  pin_out_reg;
    logic        ovf_out_reg;
    logic [2:0]  hit_out_reg;

    logic advance;
    logic take_item;

    // the input item moves on when the result register is free or being drained
    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || advance;
    assign take_item  = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WAVEFORM:  cfg_reg.waveform_mode   <= cfg_data;
                CFG_PRESCALE:  cfg_reg.prescale_select <= cfg_data;
                CFG_COMPARE_A: cfg_reg.compare_mode[0] <= cfg_data[2:0];
                CFG_COMPARE_B: cfg_reg.compare_mode[1] <= cfg_data[2:0];
                CFG_COMPARE_C: cfg_reg.compare_mode[2] <= cfg_data[2:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item_ready)
            in_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            op_reg        <= operation;
            new_count_reg <= new_count;
            ocr_a_reg     <= ocr_a_buffer;
            ocr_b_reg     <= ocr_b_buffer;
            ocr_c_reg     <= ocr_c_buffer;
            icr_reg       <= capture_top;
        end
    end

    ptc_step #(
        .COUNTER_BITS (COUNTER_BITS),
        .NUM_COMPARE  (NUM_COMPARE)
    ) u_step (
        .cfg                 (cfg_reg),
        .op_write            (op_reg),
        .new_count           (new_count_reg[COUNTER_BITS-1:0]),
        .icr                 (icr_reg[COUNTER_BITS-1:0]),
        .ocr_buf             ({ocr_c_reg[COUNTER_BITS-1:0],
                               ocr_b_reg[COUNTER_BITS-1:0],
                               ocr_a_reg[COUNTER_BITS-1:0]}),
        .prescale_count      (pc_reg),
        .counter             (counter_reg),
        .count_down          (down_reg),
        .shadow              (shadow_reg),
        .pins                (pins_reg),
        .prescale_count_next (pc_next),
        .counter_next        (counter_next),
        .count_down_next     (down_next),
        .shadow_next         (shadow_next),
        .pins_next           (pins_next),
        .overflow_hit        (ovf_calc),
        .match_hit           (hit_calc)
    );

    // timer state commits as the item moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= '0;
            counter_reg <= '0;
            down_reg    <= 1'b0;
            shadow_reg  <= '0;
            pins_reg    <= '0;
        end
        else if (advance)
        begin
            pc_reg      <= pc_next;
            counter_reg <= counter_next;
            down_reg    <= down_next;
            shadow_reg  <= shadow_next;
            pins_reg    <= pins_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            count_now_reg <= 16'(counter_next);
            pin_out_reg   <= pins_next;
            ovf_out_reg   <= ovf_calc;
            hit_out_reg   <= hit_calc;
        end
    end

    assign result_valid = out_valid_reg;
    assign count_now    = count_now_reg;
    assign pin_a        = pin_out_reg[0];
    assign pin_b        = pin_out_reg[1];
    assign pin_c        = pin_out_reg[2];
    assign overflow_hit = ovf_out_reg;
    assign match_a_hit  = hit_out_reg[0];
    assign match_b_hit  = hit_out_reg[1];
    assign match_c_hit  = hit_out_reg[2];

    // a moving item always leaves a result behind
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not loaded after item moved");

    // a held item must not touch the timer state
    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> ($stable(counter_reg) && $stable(pc_reg)))
        else $error("timer state changed while input stage stalled");

    // a counter write leaves prescaler alone and raises no hit
    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && op_reg) |=> ($stable(pc_reg) && !ovf_out_reg && (hit_out_reg == 3'b000)))
        else $error("counter write disturbed prescaler or flags");

    // pin of channel c stays low when that channel is absent
    a_absent_pin_low: assert property (@(posedge clk) disable iff (!rst_n)
        (NUM_COMPARE < 3) |-> !pins_reg[2])
        else $error("pin of absent channel driven high");

endmodule

`default_nettype wire

/* verif/pwm_timer_counter_core_test.sv */
// pwm_timer_counter_core_test: self-checking testbench of the pwm timer counter core
`timescale 1ns / 100ps

module pwm_timer_counter_core_test;
    import ptc_pkg::*;

    // pin action after a pwm extreme has pinned the channel level
    localparam logic [3:0] ACT_FORCED = 4'd8;
    localparam int REPORT_LIMIT = 10;
    localparam int RANDOM_ITEMS = 750;

    // one item transfer as driven on the item channel
    typedef struct packed {
        logic        operation;
        logic [15:0] new_count;
        logic [15:0] ocr_a;
        logic [15:0] ocr_b;
        logic [15:0] ocr_c;
        logic [15:0] capture_top;
    } tick_item_t;

    // one result transfer; bit 0 is channel a, bit 2 channel c
    typedef struct packed {
        logic [15:0] count_now;
        logic [2:0]  pin;
        logic        overflow;
        logic [2:0]  match;
    } timer_out_t;

    // timer model plus the queue of outputs still owed by the block
    class ptc_scoreboard;
        logic [3:0]  waveform;
        logic [3:0]  prescale;
        logic [2:0]  cmode [3];
        logic [9:0]  prescale_count;
        logic [15:0] counter;
        logic        counting_down;
        logic [15:0] shadow [3];
        logic        pin_level [3];

        timer_out_t  pending_outputs [$];
        int          mismatches;
        int          results_checked;
        int          overflow_pulses;
        int          match_pulses;

        function new();
            waveform = WGM_FREE_RUN;
            prescale = 4'd0;
            prescale_count = '0;
            counter = '0;
            counting_down = 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                cmode[i] = CM_OFF;
                shadow[i] = '0;
                pin_level[i] = 1'b0;
            end
            mismatches = 0;
            results_checked = 0;
            overflow_pulses = 0;
            match_pulses = 0;
        endfunction

        function void set_reg(logic [2:0] index, logic [3:0] data);
            case (index)
                CFG_WAVEFORM:  waveform = data;
                CFG_PRESCALE:  prescale = data;
                CFG_COMPARE_A: cmode[0] = data[2:0];
                CFG_COMPARE_B: cmode[1] = data[2:0];
                CFG_COMPARE_C: cmode[2] = data[2:0];
                default: ;
            endcase
        endfunction

        // one item through the timer: prescaler, waveform, pins, hit pulses
        function timer_out_t advance_timer(tick_item_t it);
            timer_out_t  res;
            int unsigned clk_v, top, ovf, sync, rev, nxt, mask;
            logic [1:0]  kind;
            logic        has_rev, rev_follows, lowish, highish, counts;
            logic [3:0]  act;
            logic [15:0] cmp;
            logic [15:0] buffers [3];

            res = '0;
            counts = 1'b0;
            has_rev = 1'b0;
            rev_follows = 1'b0;
            rev = 0;
            ovf = 0;
            if (it.operation)
                counter = it.new_count;
            else if (prescale != 4'd0 && prescale <= PRESCALE_MAX)
            begin
                prescale_count = prescale_count + 10'd1;
                mask = (32'd1 << (prescale - 1)) - 1;
                counts = ((prescale_count & mask[9:0]) == 10'd0) && (waveform != WGM_HOLD);
            end

            if (counts)
            begin
                clk_v = counter;
                kind = KIND_PLAIN;
                case (waveform)
                    WGM_FREE_RUN:   begin top = 16'hffff; ovf = 16'hffff; sync = clk_v; end
                    WGM_CTC_ICR:    begin top = it.capture_top; ovf = 16'hffff; sync = clk_v; end
                    WGM_CTC_OCRA:   begin top = shadow[0]; ovf = 16'hffff; sync = clk_v; end
                    WGM_FAST_8:     begin top = TOP_8; ovf = top; sync = 0; kind = KIND_FAST; end
                    WGM_FAST_9:     begin top = TOP_9; ovf = top; sync = 0; kind = KIND_FAST; end
                    WGM_FAST_10:    begin top = TOP_10; ovf = top; sync = 0; kind = KIND_FAST; end
                    WGM_FAST_ICR:   begin top = it.capture_top; ovf = top; sync = 0; kind = KIND_FAST; end
                    WGM_FAST_OCRA:  begin top = shadow[0]; ovf = top; sync = 0; kind = KIND_FAST; end
                    WGM_PHASE_8:    begin top = TOP_8; sync = top; kind = KIND_PHASE; end
                    WGM_PHASE_9:    begin top = TOP_9; sync = top; kind = KIND_PHASE; end
                    WGM_PHASE_10:   begin top = TOP_10; sync = top; kind = KIND_PHASE; end
                    WGM_PHASE_ICR:  begin top = it.capture_top; sync = top; kind = KIND_PHASE; end
                    WGM_PHASE_OCRA:
                    begin
                        top = shadow[0];
                        sync = top;
                        kind = KIND_PHASE;
                        rev_follows = 1'b1;
                    end
                    WGM_PFC_ICR:    begin top = it.capture_top; sync = 0; kind = KIND_PHASE; end
                    default:
                    begin
                        top = shadow[0];
                        sync = 0;
                        kind = KIND_PHASE;
                        rev_follows = 1'b1;
                    end
                endcase
                if (kind == KIND_PHASE)
                begin
                    ovf = 0;
                    rev = top;
                    has_rev = 1'b1;
                end

                // double buffer update at the sync point
                buffers[0] = it.ocr_a;
                buffers[1] = it.ocr_b;
                buffers[2] = it.ocr_c;
                if (sync == clk_v)
                begin
                    for (int i = 0; i < 3; i++)
                        shadow[i] = buffers[i];
                    if (rev_follows)
                        rev = shadow[0];
                end

                for (int i = 0; i < 3; i++)
                begin
                    act = {1'b0, cmode[i]};
                    cmp = shadow[i];
                    if (kind == KIND_FAST && act != CM_OFF)
                    begin
                        if (cmp == 16'd0)
                        begin
                            pin_level[i] = (clk_v == 0);
                            act = ACT_FORCED;
                        end
                        else if (cmp == top)
                        begin
                            pin_level[i] = (act == CM_INV);
                            act = ACT_FORCED;
                        end
                    end
                    else if (kind == KIND_PHASE)
                    begin
                        lowish = (act == CM_NONINV) || (act == CM_CLRUP);
                        highish = (act == CM_INV) || (act == CM_SETUP);
                        if ((cmp == 16'd0 && lowish) || (cmp == top && highish))
                        begin
                            pin_level[i] = 1'b0;
                            act = ACT_FORCED;
                        end
                        else if ((cmp == 16'd0 && highish) || (cmp == top && lowish))
                        begin
                            pin_level[i] = 1'b1;
                            act = ACT_FORCED;
                        end
                    end
                    if (clk_v == 0)
                    begin
                        if (act == CM_NONINV)
                            pin_level[i] = 1'b1;
                        else if (act == CM_INV)
                            pin_level[i] = 1'b0;
                    end
                    if (clk_v == cmp)
                    begin
                        res.match[i] = 1'b1;
                        if (act != CM_OFF && act != ACT_FORCED &&
                            (clk_v != top || act == CM_TOGGLE || act == CM_CLEAR ||
                             act == CM_SET))
                        begin
                            if (act == CM_TOGGLE)
                                pin_level[i] = ~pin_level[i];
                            else if (act == CM_CLEAR || act == CM_NONINV ||
                                     (act == CM_CLRUP && !counting_down) ||
                                     (act == CM_SETUP && counting_down))
                                pin_level[i] = 1'b0;
                            else
                                pin_level[i] = 1'b1;
                        end
                    end
                end
                res.overflow = (clk_v == ovf);

                if (counting_down)
                begin
                    if (clk_v == 0)
                    begin
                        nxt = 0;
                        counting_down = 1'b0;
                    end
                    else
                    begin
                        nxt = clk_v - 1;
                        if (nxt > top)
                        begin
                            nxt = 0;
                            counting_down = 1'b0;
                        end
                        else if (nxt == 0)
                            counting_down = 1'b0;
                    end
                end
                else
                begin
                    nxt = clk_v + 1;
                    if (nxt > top)
                        nxt = 0;
                end
                if (has_rev && nxt == rev)
                    counting_down = ~counting_down;
                counter = nxt[15:0];
            end

            res.count_now = counter;
            res.pin = {pin_level[2], pin_level[1], pin_level[0]};
            return res;
        endfunction

        function void note_item(tick_item_t it);
            pending_outputs.push_back(advance_timer(it));
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch in result %0d, %s: expected %0h, got %0h",
                             results_checked, field, want, got);
            end
        endfunction

        function void check_result(timer_out_t got);
            timer_out_t want;
            if (pending_outputs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result with nothing outstanding, count_now %0h", got.count_now);
                return;
            end
            want = pending_outputs.pop_front();
            compare_field("count_now", want.count_now, got.count_now);
            compare_field("pin_a", want.pin[0], got.pin[0]);
            compare_field("pin_b", want.pin[1], got.pin[1]);
            compare_field("pin_c", want.pin[2], got.pin[2]);
            compare_field("overflow_hit", want.overflow, got.overflow);
            compare_field("match_a_hit", want.match[0], got.match[0]);
            compare_field("match_b_hit", want.match[1], got.match[1]);
            compare_field("match_c_hit", want.match[2], got.match[2]);
            results_checked++;
            overflow_pulses += got.overflow;
            match_pulses += $countones(got.match);
        endfunction
    endclass

    // clock, reset and every block input start at known values
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [3:0]  cfg_data = '0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic        operation = 1'b0;
    logic [15:0] new_count = '0;
    logic [15:0] ocr_a_buffer = '0;
    logic [15:0] ocr_b_buffer = '0;
    logic [15:0] ocr_c_buffer = '0;
    logic [15:0] capture_top = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [15:0] count_now;
    logic        pin_a;
    logic        pin_b;
    logic        pin_c;
    logic        overflow_hit;
    logic        match_a_hit;
    logic        match_b_hit;
    logic        match_c_hit;

    ptc_scoreboard scoreboard = new();

    // sender burst bookkeeping and run statistics
    int          burst_left = 0;
    int          items_sent = 0;
    int          counter_writes = 0;
    int          setups = 0;

    // compare buffers and capture top that the current random phase holds on to
    logic [15:0] base_a;
    logic [15:0] base_b;
    logic [15:0] base_c;
    logic [15:0] base_icr;

    pwm_timer_counter_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .operation    (operation),
        .new_count    (new_count),
        .ocr_a_buffer (ocr_a_buffer),
        .ocr_b_buffer (ocr_b_buffer),
        .ocr_c_buffer (ocr_c_buffer),
        .capture_top  (capture_top),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .count_now    (count_now),
        .pin_a        (pin_a),
        .pin_b        (pin_b),
        .pin_c        (pin_c),
        .overflow_hit (overflow_hit),
        .match_a_hit  (match_a_hit),
        .match_b_hit  (match_b_hit),
        .match_c_hit  (match_c_hit)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result monitor: a transfer is taken at the rising edge with valid and ready high
    always @(posedge clk)
    begin
        if (result_valid && result_ready)
            scoreboard.check_result('{count_now: count_now,
                                      pin:       {pin_c, pin_b, pin_a},
                                      overflow:  overflow_hit,
                                      match:     {match_c_hit, match_b_hit, match_a_hit}});
    end

    // result sink: stall pattern redrawn at random, plus one long hold-off
    // once a few hundred results are through, while the sender keeps offering
    initial
    begin : result_sink
        int cyc;
        int style;
        int hold_left;
        bit long_hold_done;
        cyc = 0;
        style = 0;
        hold_left = 0;
        long_hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (cyc % 50 == 0)
                style = $urandom_range(0, 3);
            if (!long_hold_done && scoreboard.results_checked >= 300)
            begin
                hold_left = 90;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                case (style)
                    0: result_ready <= 1'b1;                       // no stalls at all
                    1: result_ready <= (cyc % 4 != 3);             // one stall in four
                    2: result_ready <= ($urandom_range(0, 1) == 1); // coin flip
                    default: result_ready <= (cyc % 3 == 0);       // mostly stalled
                endcase
            end
            cyc++;
        end
    end

    // one item transfer; bursts of random length separated by random gaps,
    // now and then a long unbroken run
    task automatic push_item(input tick_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 5);
            repeat (gap)
            begin
                @(negedge clk);
                item_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 10);
        end
        @(negedge clk);
        item_valid <= 1'b1;
        operation <= it.operation;
        new_count <= it.new_count;
        ocr_a_buffer <= it.ocr_a;
        ocr_b_buffer <= it.ocr_b;
        ocr_c_buffer <= it.ocr_c;
        capture_top <= it.capture_top;
        do
            @(posedge clk);
        while (!item_ready);
        scoreboard.note_item(it);
        burst_left--;
        items_sent++;
        if (it.operation)
            counter_writes++;
    endtask

    task automatic tick_once(input logic [15:0] a, b, c, icr);
        push_item('{1'b0, 16'h0000, a, b, c, icr});
    endtask

    task automatic set_count(input logic [15:0] value);
        push_item('{1'b1, value, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
    endtask

    // stop offering and wait until every outstanding result has been taken,
    // then let the two pipeline stages settle
    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        burst_left = 0;
        while (scoreboard.pending_outputs.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [3:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        scoreboard.set_reg(index, data);
    endtask

    // new timer setup, only ever written with the block idle
    task automatic apply_setup(input logic [3:0] mode, psel, input logic [2:0] ca, cb, cc);
        drain();
        write_reg(CFG_WAVEFORM, mode);
        write_reg(CFG_PRESCALE, psel);
        write_reg(CFG_COMPARE_A, {1'b0, ca});
        write_reg(CFG_COMPARE_B, {1'b0, cb});
        write_reg(CFG_COMPARE_C, {1'b0, cc});
        setups++;
    endtask

    // values biased toward bottom, top and just around top of the current period
    function automatic logic [15:0] near_span(int unsigned span);
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return span[15:0];
            2: return 16'($urandom_range(0, 65535));
            3: return 16'(span - 1);
            default: return 16'($urandom_range(0, span + 1));
        endcase
    endfunction

    // mostly the phase's held values so whole periods run, with some noise
    function automatic tick_item_t random_item(int unsigned span);
        tick_item_t it;
        it.operation = ($urandom_range(0, 24) == 0);
        it.new_count = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                   : 16'(span - $urandom_range(0, 4));
        it.ocr_a = ($urandom_range(0, 9) == 0) ? near_span(span) : base_a;
        it.ocr_b = ($urandom_range(0, 9) == 0) ? near_span(span) : base_b;
        it.ocr_c = ($urandom_range(0, 9) == 0) ? near_span(span) : base_c;
        it.capture_top = ($urandom_range(0, 19) == 0) ? near_span(span) : base_icr;
        return it;
    endfunction

    // run watchdog, far beyond the slowest legal run
    initial
    begin
        #(3_000_000);
        $display("pwm_timer_counter_core_test: done, errors");
        $finish;
    end

    initial
    begin : main_flow
        int          phase;
        int          phase_len;
        int          random_items;
        int          r;
        int unsigned span;
        logic [3:0]  mode;
        logic [3:0]  psel;
        tick_item_t  it;

        // reset held, then released away from the active edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // timer stopped after reset: ticks do nothing, a counter write still loads
        tick_once(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        tick_once(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        set_count(16'hffff);

        // free-running mode across the overflow with toggle, clear and set channels
        apply_setup(WGM_FREE_RUN, 4'd1, CM_TOGGLE, CM_CLEAR, CM_SET);
        set_count(16'hfffe);
        tick_once(16'hffff, 16'hfffe, 16'h0000, 16'h0000);
        tick_once(16'hffff, 16'hfffe, 16'h0000, 16'h0000);
        tick_once(16'hffff, 16'hfffe, 16'h0000, 16'h0000);

        // hold mode: only the prescaler moves
        apply_setup(WGM_HOLD, 4'd2, CM_NONINV, CM_INV, CM_TOGGLE);
        tick_once(16'h0001, 16'h0002, 16'h0003, 16'h0004);
        tick_once(16'h0001, 16'h0002, 16'h0003, 16'h0004);

        // fast pwm at its wrap, compare 0 and compare at top
        apply_setup(WGM_FAST_8, 4'd1, CM_NONINV, CM_INV, CM_TOGGLE);
        set_count(16'h00fe);
        tick_once(16'h0000, 16'h00ff, 16'h0080, 16'h0000);
        tick_once(16'h0000, 16'h00ff, 16'h0080, 16'h0000);
        tick_once(16'h0000, 16'h00ff, 16'h0080, 16'h0000);

        // phase pwm: reversal at top, bottom visit, and a counter above top
        apply_setup(WGM_PHASE_8, 4'd1, CM_CLRUP, CM_SETUP, CM_NONINV);
        set_count(16'h00fe);
        tick_once(16'h0000, 16'h00ff, 16'h0010, 16'h0000);
        tick_once(16'h0000, 16'h00ff, 16'h0010, 16'h0000);
        set_count(16'h0001);
        tick_once(16'h0000, 16'h00ff, 16'h0010, 16'h0000);
        set_count(16'h0300);
        tick_once(16'h0000, 16'h00ff, 16'h0010, 16'h0000);

        // phase-freq with shadow a as top: reversal follows the freshly loaded value
        apply_setup(WGM_PFC_OCRA, 4'd1, CM_TOGGLE, CM_CLRUP, CM_INV);
        set_count(16'h0000);
        repeat (4) tick_once(16'h0003, 16'h0001, 16'h0003, 16'h0000);

        // random phases: one timer setup each, walking all waveform modes first;
        // the first phases take the prescaler extremes
        phase = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            mode = (phase < 16) ? 4'(phase) : 4'($urandom_range(0, 15));
            r = $urandom_range(0, 19);
            if (phase == 0)
                psel = PRESCALE_MAX;
            else if (phase == 1)
                psel = 4'd0;
            else if (phase == 2)
                psel = 4'd15;
            else if (r == 0)
                psel = 4'd0;
            else if (r == 1)
                psel = 4'($urandom_range(12, 15));
            else if (r < 5)
                psel = 4'($urandom_range(2, 4));
            else
                psel = 4'd1;

            // small periods in the capture and shadow-a modes so many periods complete
            base_icr = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                                   : 16'($urandom_range(0, 48));
            base_a = 16'($urandom_range(0, 48));
            case (mode)
                WGM_CTC_ICR, WGM_FAST_ICR, WGM_PHASE_ICR, WGM_PFC_ICR:    span = base_icr;
                WGM_CTC_OCRA, WGM_FAST_OCRA, WGM_PHASE_OCRA, WGM_PFC_OCRA: span = base_a;
                WGM_FAST_8, WGM_PHASE_8:   span = TOP_8;
                WGM_FAST_9, WGM_PHASE_9:   span = TOP_9;
                WGM_FAST_10, WGM_PHASE_10: span = TOP_10;
                default:                   span = 16'hffff;
            endcase
            if (!(mode inside {WGM_CTC_OCRA, WGM_FAST_OCRA, WGM_PHASE_OCRA, WGM_PFC_OCRA}))
                base_a = near_span(span);
            base_b = near_span(span);
            base_c = near_span(span);

            apply_setup(mode, psel, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                        3'($urandom_range(0, 7)));

            // each phase opens with a counter write near the interesting points
            it = random_item(span);
            it.operation = 1'b1;
            push_item(it);
            phase_len = $urandom_range(30, 60);
            repeat (phase_len) push_item(random_item(span));
            random_items += phase_len + 1;
            phase++;
        end

        drain();
        $display("covered %0d item transfers (%0d counter writes) over %0d timer setups",
                 items_sent, counter_writes, setups);
        $display("checked %0d results: %0d overflow pulses, %0d compare match pulses",
                 scoreboard.results_checked, scoreboard.overflow_pulses,
                 scoreboard.match_pulses);
        if (scoreboard.mismatches == 0 && scoreboard.pending_outputs.size() == 0)
            $display("pwm_timer_counter_core_test: done, clean");
        else
            $display("pwm_timer_counter_core_test: done, errors");
        $finish;
    end

endmodule
